/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Implication whose consequent is checked at the next clock edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

/* hw/rtl/rvx_pkg.sv */
// ----------------------------------------------------------------------------
// RV64IM execute package
// Operation codes, field widths and the control/status structs.
// ----------------------------------------------------------------------------
package rvx_pkg;
	localparam int XLEN      = 64;
	localparam int REG_COUNT = 32;
	localparam int REG_IDX_W = 5;

	localparam logic [4:0] F_ADD    = 5'd0;
	localparam logic [4:0] F_SUB    = 5'd1;
	localparam logic [4:0] F_AND    = 5'd2;
	localparam logic [4:0] F_OR     = 5'd3;
	localparam logic [4:0] F_XOR    = 5'd4;
	localparam logic [4:0] F_SLL    = 5'd5;
	localparam logic [4:0] F_SRL    = 5'd6;
	localparam logic [4:0] F_SRA    = 5'd7;
	localparam logic [4:0] F_SLT    = 5'd8;
	localparam logic [4:0] F_SLTU   = 5'd9;
	localparam logic [4:0] F_MUL    = 5'd10;
	localparam logic [4:0] F_MULH   = 5'd11;
	localparam logic [4:0] F_MULHSU = 5'd12;
	localparam logic [4:0] F_MULHU  = 5'd13;
	localparam logic [4:0] F_DIV    = 5'd14;
	localparam logic [4:0] F_DIVU   = 5'd15;
	localparam logic [4:0] F_REM    = 5'd16;
	localparam logic [4:0] F_REMU   = 5'd17;
	localparam logic [4:0] F_BEQ    = 5'd18;
	localparam logic [4:0] F_BNE    = 5'd19;
	localparam logic [4:0] F_BLT    = 5'd20;
	localparam logic [4:0] F_BGE    = 5'd21;
	localparam logic [4:0] F_BLTU   = 5'd22;
	localparam logic [4:0] F_BGEU   = 5'd23;
	localparam logic [4:0] F_JAL    = 5'd24;
	localparam logic [4:0] F_JALR   = 5'd25;
	localparam logic [4:0] F_LUI    = 5'd26;
	localparam logic [4:0] F_AUIPC  = 5'd27;

	// Decoded instruction as held by the datapath.
	typedef struct packed {
		logic [4:0]  func;
		logic        word_op;
		logic        use_imm;
		logic [4:0]  dest_reg;
		logic [4:0]  src_reg_a;
		logic [4:0]  src_reg_b;
		logic [31:0] immediate;
		logic [63:0] pc;
		logic [2:0]  inst_len;
	} instr_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // capture instruction and read operands
		logic mul_start; // begin multiply sequence
		logic mul_step;  // one partial product
		logic div_start; // begin division
		logic div_step;  // one quotient bit
		logic finish;    // form result into the output register
		logic commit;    // write the register file
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_mul;
		logic is_div;
		logic mul_last;
		logic div_last;
	} sts_t;
endpackage

/* hw/rtl/rv64im_integer_execute.sv */
// ----------------------------------------------------------------------------
// RV64IM integer execute unit
// Executes one decoded integer instruction at a time with its own registers.
// ----------------------------------------------------------------------------
// The unit takes one decoded instruction per item and returns one result item
// with the register write-back and the next pc. It works on one item at a
// time: simple operations go from decode straight to the finish state, a
// multiply steps through eight 32-by-16 partial products on one shared
// multiplier and a divide or remainder produces one quotient bit per
// cycle in a restoring divider. A new item is accepted once the previous
// result has been placed in the output register, which may still be waiting
// to be taken. Register x0 reads zero; all registers read zero after reset.
// Division by zero and signed overflow give the RISC-V architectural results.
module rv64im_integer_execute (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// func[4:0], word_op[5], use_imm[6], dest_reg[11:7], src_reg_a[16:12],
	// src_reg_b[21:17], immediate[53:22], pc[117:54], inst_len[120:118]
	input  logic [127:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// wb_reg[4:0], wb_value[68:5], wb_enable[69], next_pc[133:70], taken[134]
	output logic [135:0] m_tdata
);
	rvx_pkg::instr_t instr;
	rvx_pkg::cmd_t   cmd;
	rvx_pkg::sts_t   sts;
	logic [4:0]  wb_reg;
	logic [63:0] wb_value, next_pc;
	logic        wb_enable, taken;

	// Unpack the slave-side item.
	assign instr.func      = s_tdata[4:0];
	assign instr.word_op   = s_tdata[5];
	assign instr.use_imm   = s_tdata[6];
	assign instr.dest_reg  = s_tdata[11:7];
	assign instr.src_reg_a = s_tdata[16:12];
	assign instr.src_reg_b = s_tdata[21:17];
	assign instr.immediate = s_tdata[53:22];
	assign instr.pc        = s_tdata[117:54];
	assign instr.inst_len  = s_tdata[120:118];

	rvx_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rvx_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_instr  (instr),
		.cmd       (cmd),
		.sts       (sts),
		.wb_reg    (wb_reg),
		.wb_value  (wb_value),
		.wb_enable (wb_enable),
		.next_pc   (next_pc),
		.taken     (taken)
	);

	// Pack the result item; the top bit is padding.
	assign m_tdata = {1'b0, taken, next_pc, wb_enable, wb_value, wb_reg};
endmodule

/* hw/rtl/rvx_ctrl.sv */
// ----------------------------------------------------------------------------
// RV64IM execute controller
// Sequences operand read, the multi-cycle units and result delivery.
// ----------------------------------------------------------------------------
module rvx_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  rvx_pkg::sts_t  sts,
	output rvx_pkg::cmd_t  cmd
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DEC  = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	logic [2:0] state_q, state_d;
	logic       out_valid_q;
	logic       out_free;

	// The output register may be refilled when empty or being taken.
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DEC;
				end
			end
			S_DEC: begin
				if (sts.is_mul) begin
					cmd.mul_start = 1'b1;
					state_d       = S_MUL;
				end else if (sts.is_div) begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end else begin
					state_d = S_FIN;
				end
			end
			S_MUL: begin
				cmd.mul_step = 1'b1;
				if (sts.mul_last) state_d = S_FIN;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) state_d = S_FIN;
			end
			S_FIN: begin
				if (out_free) begin
					cmd.finish = 1'b1;
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end
endmodule

/* hw/rtl/rvx_dp.sv */
// ----------------------------------------------------------------------------
// RV64IM execute datapath
// Register file, ALU, iterative multiplier and divider, branch unit.
// ----------------------------------------------------------------------------
module rvx_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  rvx_pkg::instr_t in_instr,
	input  rvx_pkg::cmd_t   cmd,
	output rvx_pkg::sts_t   sts,
	output logic [4:0]      wb_reg,
	output logic [63:0]     wb_value,
	output logic            wb_enable,
	output logic [63:0]     next_pc,
	output logic            taken
);
	rvx_pkg::instr_t ins_q;
	logic [63:0] a_q, rs2_q;
	logic [63:0] regs_q [rvx_pkg::REG_COUNT];
	logic [rvx_pkg::REG_COUNT-1:0] vld_q;

	logic [63:0] imm, b, fall, val, nxt, wa, wb;
	logic        writes, tk, word;
	logic [5:0]  sh;

	// Multiplier: 2 x 4 partial products of 32x16 bits.
	logic [127:0] prod_q;
	logic [63:0]  ma_q, mb_q;
	logic [2:0]   mcnt_q;
	logic         mneg_q;
	// Divider: restoring, one bit per cycle.
	logic [63:0]  dq_q, dr_q, dd_q;
	logic [6:0]   dcnt_q;
	logic         qneg_q, rneg_q, dzero_q;
	logic [63:0]  ovf_q;
	logic [65:0]  dtry;
	logic [64:0]  dshift;

	function automatic logic [63:0] rd_reg(input logic [4:0] i,
	                                       input logic [rvx_pkg::REG_COUNT-1:0] v,
	                                       input logic [63:0] d);
		rd_reg = (i == 5'd0 || !v[i]) ? 64'd0 : d;
	endfunction

	function automatic logic [63:0] sx32(input logic [63:0] x);
		sx32 = {{32{x[31]}}, x[31:0]};
	endfunction

	assign imm  = {{32{ins_q.immediate[31]}}, ins_q.immediate};
	assign b    = ins_q.use_imm ? imm : rs2_q;
	assign fall = ins_q.pc + {61'd0, ins_q.inst_len};
	assign wa   = ins_q.word_op ? {32'd0, a_q[31:0]} : a_q;
	assign wb   = ins_q.word_op ? {32'd0, b[31:0]} : b;
	assign sh   = ins_q.word_op ? {1'b0, b[4:0]} : b[5:0];

	assign sts.is_mul   = (ins_q.func >= rvx_pkg::F_MUL) && (ins_q.func <= rvx_pkg::F_MULHU);
	assign sts.is_div   = (ins_q.func >= rvx_pkg::F_DIV) && (ins_q.func <= rvx_pkg::F_REMU);
	assign sts.mul_last = (mcnt_q == 3'd7);
	assign sts.div_last = (dcnt_q == 7'd63);

	// Operand capture and register file.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ins_q <= in_instr;
			a_q   <= rd_reg(in_instr.src_reg_a, vld_q, regs_q[in_instr.src_reg_a]);
			rs2_q <= rd_reg(in_instr.src_reg_b, vld_q, regs_q[in_instr.src_reg_b]);
		end
		if (cmd.commit && writes) regs_q[ins_q.dest_reg] <= val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (cmd.commit && writes) vld_q[ins_q.dest_reg] <= 1'b1;
	end

	// Multiply: unsigned magnitudes, sign fixed at the end.
	logic        sa_mul, sb_mul;
	logic [63:0] ua, ub;
	logic [31:0] pa;
	logic [15:0] pb;
	logic [47:0] pp;
	always_comb begin
		sa_mul = (ins_q.func == rvx_pkg::F_MULH || ins_q.func == rvx_pkg::F_MULHSU)
		         && a_q[63];
		sb_mul = (ins_q.func == rvx_pkg::F_MULH) && b[63];
		ua = sa_mul ? -a_q : a_q;
		ub = sb_mul ? -b : b;
		pa = mcnt_q[2] ? ma_q[63:32] : ma_q[31:0];
		case (mcnt_q[1:0])
			2'd0: pb = mb_q[15:0];
			2'd1: pb = mb_q[31:16];
			2'd2: pb = mb_q[47:32];
			default: pb = mb_q[63:48];
		endcase
		pp = pa * pb;
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_start) begin
			ma_q   <= ua;
			mb_q   <= ub;
			mneg_q <= sa_mul ^ sb_mul;
			mcnt_q <= 3'd0;
			prod_q <= '0;
		end else if (cmd.mul_step) begin
			prod_q <= prod_q + ({80'd0, pp} << {mcnt_q[2], 5'd0} << {mcnt_q[1:0], 4'd0});
			mcnt_q <= mcnt_q + 3'd1;
		end
	end

	// Divide: signed operands as magnitudes. The shifted partial remainder
	// needs one bit more than the divisor, since a divisor above 2^63 leaves
	// remainders with the top bit set.
	logic        sdiv, na, nb;
	logic [63:0] da, db, uda, udb;
	always_comb begin
		sdiv = (ins_q.func == rvx_pkg::F_DIV || ins_q.func == rvx_pkg::F_REM);
		if (sdiv) begin
			da = ins_q.word_op ? sx32(a_q) : a_q;
			db = ins_q.word_op ? sx32(b) : b;
		end else begin
			da = wa;
			db = wb;
		end
		na  = sdiv && da[63];
		nb  = sdiv && db[63];
		uda = na ? -da : da;
		udb = nb ? -db : db;
		dshift = {dr_q, dq_q[63]};
		dtry   = {1'b0, dshift} - {2'b0, dd_q};
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dq_q    <= uda;
			dr_q    <= '0;
			dd_q    <= udb;
			dcnt_q  <= '0;
			qneg_q  <= na ^ nb;
			rneg_q  <= na;
			dzero_q <= (db == 64'd0);
			ovf_q   <= da;
		end else if (cmd.div_step) begin
			dcnt_q <= dcnt_q + 7'd1;
			if (!dtry[65]) begin
				dr_q <= dtry[63:0];
				dq_q <= {dq_q[62:0], 1'b1};
			end else begin
				dr_q <= dshift[63:0];
				dq_q <= {dq_q[62:0], 1'b0};
			end
		end
	end

	// Result selection. ovf_q keeps the dividend for divide-by-zero.
	logic [127:0] sprod;
	logic [63:0]  dquo, drem;
	always_comb begin
		sprod  = mneg_q ? -prod_q : prod_q;
		dquo   = qneg_q ? -dq_q : dq_q;
		drem   = rneg_q ? -dr_q : dr_q;
		val    = '0;
		nxt    = fall;
		writes = 1'b1;
		tk     = 1'b0;
		word   = 1'b0;
		unique case (ins_q.func)
			rvx_pkg::F_ADD: begin val = a_q + b; word = ins_q.word_op; end
			rvx_pkg::F_SUB: begin val = a_q - b; word = ins_q.word_op; end
			rvx_pkg::F_AND: val = a_q & b;
			rvx_pkg::F_OR:  val = a_q | b;
			rvx_pkg::F_XOR: val = a_q ^ b;
			rvx_pkg::F_SLL: begin val = a_q << sh; word = ins_q.word_op; end
			rvx_pkg::F_SRL: begin val = wa >> sh; word = ins_q.word_op; end
			rvx_pkg::F_SRA: begin
				val  = $signed(ins_q.word_op ? sx32(a_q) : a_q) >>> sh;
				word = ins_q.word_op;
			end
			rvx_pkg::F_SLT:  val = {63'd0, $signed(a_q) < $signed(b)};
			rvx_pkg::F_SLTU: val = {63'd0, a_q < b};
			rvx_pkg::F_MUL:  begin val = prod_q[63:0]; word = ins_q.word_op; end
			rvx_pkg::F_MULH, rvx_pkg::F_MULHSU, rvx_pkg::F_MULHU: val = sprod[127:64];
			rvx_pkg::F_DIV, rvx_pkg::F_DIVU: begin
				val  = dzero_q ? '1 : dquo;
				word = ins_q.word_op;
			end
			rvx_pkg::F_REM, rvx_pkg::F_REMU: begin
				val  = dzero_q ? ovf_q : drem;
				word = ins_q.word_op;
			end
			rvx_pkg::F_BEQ, rvx_pkg::F_BNE, rvx_pkg::F_BLT,
			rvx_pkg::F_BGE, rvx_pkg::F_BLTU, rvx_pkg::F_BGEU: begin
				writes = 1'b0;
				case (ins_q.func)
					rvx_pkg::F_BEQ:  tk = (a_q == rs2_q);
					rvx_pkg::F_BNE:  tk = (a_q != rs2_q);
					rvx_pkg::F_BLT:  tk = ($signed(a_q) < $signed(rs2_q));
					rvx_pkg::F_BGE:  tk = !($signed(a_q) < $signed(rs2_q));
					rvx_pkg::F_BLTU: tk = (a_q < rs2_q);
					default:         tk = (a_q >= rs2_q);
				endcase
				if (tk) nxt = ins_q.pc + imm;
			end
			rvx_pkg::F_JAL:   begin val = fall; nxt = ins_q.pc + imm; tk = 1'b1; end
			rvx_pkg::F_JALR: begin
				val = fall;
				nxt = (a_q + imm) & ~64'd1;
				tk  = 1'b1;
			end
			rvx_pkg::F_LUI:   val = imm;
			rvx_pkg::F_AUIPC: val = ins_q.pc + imm;
			default: writes = 1'b0;
		endcase
		if (word) val = sx32(val);
		if (ins_q.dest_reg == 5'd0) writes = 1'b0;
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			wb_reg    <= writes ? ins_q.dest_reg : 5'd0;
			wb_value  <= writes ? val : 64'd0;
			wb_enable <= writes;
			next_pc   <= nxt;
			taken     <= tk;
		end
	end
endmodule

/* hw/rtl/rvx_checker.sv */
// ----------------------------------------------------------------------------
// RV64IM execute port checker
// Checks the stream ports of the execute unit over time.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module rvx_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [135:0] m_tdata
);
	`ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
	`ASSERT_IMPL(a_wb_zero, clk, arst_n, m_tvalid && !m_tdata[69], m_tdata[68:0] == 69'd0, "write-back fields not zero without enable")
	`ASSERT_IMPL(a_x0, clk, arst_n, m_tvalid && m_tdata[69], m_tdata[4:0] != 5'd0, "write to x0 reported")
	`ASSERT_NEXT(a_one, clk, arst_n, s_tvalid && s_tready, !s_tready, "second item accepted while busy")
endmodule

bind rv64im_integer_execute rvx_checker u_rvx_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
